FILE: sv/skt_pkg.sv
// Shared sorted key table types: action/status/cell op codes, control bundle, FSM states.
`timescale 1ns / 1ps

package skt_pkg;

  localparam int KEY_W     = 32;
  localparam int PAYLOAD_W = 16;
  localparam int COUNT_W   = 5;
  localparam int ACTION_W  = 2;
  localparam int STATUS_W  = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_READ   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DELETE,
    OP_ROTATE
  } cell_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INSERT,
    ST_DELETE,
    ST_READ,
    ST_SINGLE
  } state_t;

  // Broadcast from the controller to every cell in the chain.
  typedef struct packed {
    cell_op_t                    op;
    logic signed [KEY_W-1:0]     key;
    logic        [PAYLOAD_W-1:0] payload;
    logic signed [KEY_W-1:0]     head_key;
    logic        [PAYLOAD_W-1:0] head_payload;
  } cell_ctl_t;

endpackage

FILE: sv/skt_cell.sv
// One slot of the sorted chain: holds a key, a payload and a valid bit.
`timescale 1ns / 1ps

module skt_cell
  import skt_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  cell_ctl_t                   ctl,
  input  logic signed [KEY_W-1:0]     left_key,
  input  logic        [PAYLOAD_W-1:0] left_payload,
  input  logic                        left_valid,
  input  logic                        left_gt,
  input  logic signed [KEY_W-1:0]     right_key,
  input  logic        [PAYLOAD_W-1:0] right_payload,
  input  logic                        right_valid,
  output logic signed [KEY_W-1:0]     key,
  output logic        [PAYLOAD_W-1:0] payload,
  output logic                        valid,
  output logic                        gt,
  output logic                        eq
);

  logic signed [KEY_W-1:0]     key_next;
  logic        [PAYLOAD_W-1:0] payload_next;
  logic                        valid_next;
  logic                        ge;

  // An empty slot counts as greater than any key.
  assign gt = !valid || (key > ctl.key);
  assign ge = !valid || (key >= ctl.key);
  assign eq = valid && (key == ctl.key);

  always_comb begin
    key_next     = key;
    payload_next = payload;
    valid_next   = valid;
    case (ctl.op)
      OP_INSERT: begin
        if (gt && left_gt) begin
          key_next     = left_key;
          payload_next = left_payload;
          valid_next   = left_valid;
        end else if (gt) begin
          key_next     = ctl.key;
          payload_next = ctl.payload;
          valid_next   = 1'b1;
        end
      end
      OP_DELETE: begin
        if (ge) begin
          key_next     = right_key;
          payload_next = right_payload;
          valid_next   = right_valid;
        end
      end
      OP_ROTATE: begin
        // The head entry wraps around into the last valid slot.
        if (valid) begin
          key_next     = right_valid ? right_key     : ctl.head_key;
          payload_next = right_valid ? right_payload : ctl.head_payload;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    key     <= key_next;
    payload <= payload_next;
  end

endmodule

FILE: sv/sorted_key_table.sv
// Top level of the sorted key table: command FSM, cell chain and result register.
`timescale 1ns / 1ps
//
// Usage:
//   Slave channel s_*: one word per command. s_tuser carries the action
//   (insert, delete all matching key, read out); s_tdata carries key and
//   payload. Master channel m_*: result words; m_tlast marks the final
//   result of a command.
// Command flow:
//   Insert: accepted in ST_IDLE, then ST_INSERT loads the result register.
//   Delete: the chain drops one matching entry per cycle (equal keys sit
//   next to each other); the result is loaded once none is left.
//   Read-out: the chain rotates one slot per cycle while the result register
//   is free; slot 0 feeds the result register.
//   One command is in flight at a time; s_tready is high only when idle.
// Reset: rst (synchronous) empties the table and drops any pending result.
// Stall: while m_tready is low the result register holds its word; insert
//   and read-out hold the chain still, a delete keeps dropping matches and
//   then waits. Work resumes in the cycle the word is taken.
//
module sorted_key_table
  import skt_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // key[31:0], payload[47:32]
  input  logic [1:0]  s_tuser,   // action[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // out_key[31:0], out_payload[47:32],
                                 // entry_count[52:48], removed[57:53],
                                 // status[59:58], zero[63:60]
  output logic        m_tlast
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  state_t                      state, state_next;
  logic signed [KEY_W-1:0]     cmd_key;
  logic        [PAYLOAD_W-1:0] cmd_payload;
  logic        [CW-1:0]        count, count_next;
  logic        [CW-1:0]        rem_cnt, rem_cnt_next;
  logic        [CW-1:0]        rd_idx, rd_idx_next;

  cell_ctl_t ctl;

  logic signed [KEY_W-1:0]     c_key     [TABLE_DEPTH];
  logic        [PAYLOAD_W-1:0] c_payload [TABLE_DEPTH];
  logic        [TABLE_DEPTH-1:0] c_valid;
  logic        [TABLE_DEPTH-1:0] c_gt;
  logic        [TABLE_DEPTH-1:0] c_eq;

  logic                        in_accept;
  logic                        out_free;
  logic                        match_any;
  logic                        full;
  logic                        read_last;

  // Result register load
  logic                        load_out;
  logic signed [KEY_W-1:0]     res_key;
  logic        [PAYLOAD_W-1:0] res_payload;
  logic        [CW-1:0]        res_count;
  logic        [CW-1:0]        res_removed;
  status_t                     res_status;
  logic                        res_last;

  assign in_accept = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign match_any = |c_eq;
  assign full      = (count == CW'(TABLE_DEPTH));
  assign read_last = (rd_idx == count - CW'(1));

  // ------------------------------------------------------------------
  // Cell chain: each slot talks only to its two neighbors plus the
  // broadcast control word.
  // ------------------------------------------------------------------
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic signed [KEY_W-1:0]     l_key, r_key;
    logic        [PAYLOAD_W-1:0] l_payload, r_payload;
    logic                        l_valid, l_gt, r_valid;

    if (i == 0) begin : g_head
      assign l_key     = '0;
      assign l_payload = '0;
      assign l_valid   = 1'b0;
      assign l_gt      = 1'b0;
    end else begin : g_mid
      assign l_key     = c_key[i-1];
      assign l_payload = c_payload[i-1];
      assign l_valid   = c_valid[i-1];
      assign l_gt      = c_gt[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign r_key     = '0;
      assign r_payload = '0;
      assign r_valid   = 1'b0;
    end else begin : g_body
      assign r_key     = c_key[i+1];
      assign r_payload = c_payload[i+1];
      assign r_valid   = c_valid[i+1];
    end

    skt_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctl          (ctl),
      .left_key     (l_key),
      .left_payload (l_payload),
      .left_valid   (l_valid),
      .left_gt      (l_gt),
      .right_key    (r_key),
      .right_payload(r_payload),
      .right_valid  (r_valid),
      .key          (c_key[i]),
      .payload      (c_payload[i]),
      .valid        (c_valid[i]),
      .gt           (c_gt[i]),
      .eq           (c_eq[i])
    );
  end

  // ------------------------------------------------------------------
  // Command FSM
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count   <= '0;
      rem_cnt <= '0;
      rd_idx  <= '0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      rem_cnt <= rem_cnt_next;
      rd_idx  <= rd_idx_next;
    end
  end

  // Latch the command word on accept
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_key     <= s_tdata[31:0];
      cmd_payload <= s_tdata[47:32];
    end
  end

  always_comb begin
    state_next   = state;
    count_next   = count;
    rem_cnt_next = rem_cnt;
    rd_idx_next  = rd_idx;
    s_tready     = 1'b0;

    ctl.op           = OP_HOLD;
    ctl.key          = cmd_key;
    ctl.payload      = cmd_payload;
    ctl.head_key     = c_key[0];
    ctl.head_payload = c_payload[0];

    load_out    = 1'b0;
    res_key     = '0;
    res_payload = '0;
    res_count   = count;
    res_removed = '0;
    res_status  = STAT_OK;
    res_last    = 1'b1;

    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (in_accept) begin
          rem_cnt_next = '0;
          rd_idx_next  = '0;
          case (action_t'(s_tuser))
            ACT_INSERT: state_next = ST_INSERT;
            ACT_DELETE: state_next = ST_DELETE;
            ACT_READ:   state_next = ST_READ;
            default:    state_next = ST_SINGLE;
          endcase
        end
      end

      ST_INSERT: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
          if (full) begin
            res_status = STAT_FULL;
          end else begin
            ctl.op     = OP_INSERT;
            count_next = count + CW'(1);
            res_count  = count + CW'(1);
          end
        end
      end

      ST_DELETE: begin
        // Drop one matching entry per cycle, report once none is left
        if (match_any) begin
          ctl.op       = OP_DELETE;
          count_next   = count - CW'(1);
          rem_cnt_next = rem_cnt + CW'(1);
        end else if (out_free) begin
          load_out    = 1'b1;
          res_removed = rem_cnt;
          state_next  = ST_IDLE;
        end
      end

      ST_READ: begin
        if (out_free) begin
          load_out = 1'b1;
          if (count == '0) begin
            res_status = STAT_EMPTY;
            state_next = ST_IDLE;
          end else begin
            ctl.op      = OP_ROTATE;
            res_key     = c_key[0];
            res_payload = c_payload[0];
            res_last    = read_last;
            rd_idx_next = rd_idx + CW'(1);
            if (read_last) begin
              state_next = ST_IDLE;
            end
          end
        end
      end

      ST_SINGLE: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // ------------------------------------------------------------------
  // Result register: holds its word until the receiver takes it.
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {4'b0000, res_status, COUNT_W'(res_removed), COUNT_W'(res_count),
                  res_payload, res_key};
      m_tlast <= res_last;
    end
  end

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_valid_matches_count: assert property (@(posedge clk) disable iff (rst)
    $countones(c_valid) == int'(count))
    else $error("cell valid bits disagree with entry count");

  a_delete_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DELETE) && match_any |=> count == $past(count) - CW'(1))
    else $error("delete step did not remove one entry");

  a_read_ends_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) && load_out && res_last |=> state == ST_IDLE)
    else $error("read-out did not finish after last word");

endmodule

FILE: verif/sorted_key_table_tb.sv
// Self-checking testbench for the sorted key table: stream driver, result monitor, table predictor.
`timescale 1ns / 1ps

module sorted_key_table_tb;
  import skt_pkg::*;

  localparam int DEPTH        = 16;
  localparam int RANDOM_WORDS = 200;
  localparam int POOL_SIZE    = 12;
  localparam int QUIET_TAIL   = 40;   // last commands run with no idling on either side
  localparam int LONG_HOLD    = 400;  // receiver hold-off that backs the block up
  localparam int HOLD_AT      = 60;   // result words seen before the hold-off starts
  localparam int STALL_LIMIT  = 3000; // cycles without any handshake before giving up
  localparam int DRAIN_CYCLES = 40;

  // One command word as the sender offers it.
  typedef struct packed {
    action_t                     act;
    logic signed [KEY_W-1:0]     key;
    logic        [PAYLOAD_W-1:0] pay;
  } command_t;

  // One result word, split into its fields.
  typedef struct packed {
    logic signed [KEY_W-1:0]     out_key;
    logic        [PAYLOAD_W-1:0] out_payload;
    logic        [COUNT_W-1:0]   entry_count;
    logic        [COUNT_W-1:0]   removed;
    status_t                     status;
    logic                        last;
  } result_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata  = '0;   // key[31:0], payload[47:32]
  logic [1:0]  s_tuser  = '0;   // action[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;         // out_key[31:0], out_payload[47:32], entry_count[52:48],
                                // removed[57:53], status[59:58], zero[63:60]
  logic        m_tlast;

  sorted_key_table #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .*
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  command_t pending_commands[$];
  result_t  expected_words[$];

  // Shadow copy of the table, kept in ascending signed key order.
  logic signed [KEY_W-1:0]     shadow_keys[DEPTH];
  logic        [PAYLOAD_W-1:0] shadow_payloads[DEPTH];
  int                          shadow_count = 0;

  bit in_taken       = 1'b0;  // command word accepted at the last rising edge
  int send_gap       = 0;
  int stall_left     = 0;
  int hold_left      = 0;
  bit long_hold_done = 1'b0;
  int words_seen     = 0;
  int mismatch_count = 0;
  int idle_cycles    = 0;

  logic signed [KEY_W-1:0] key_pool[POOL_SIZE];

  // Apply one command to the shadow table and queue the result words it causes.
  task automatic predict_results(input action_t act, input logic signed [KEY_W-1:0] key,
                                 input logic [PAYLOAD_W-1:0] pay);
    int      pos;
    int      kept;
    int      i;
    result_t r;
    r = '0;
    r.status = STAT_OK;
    r.last = 1'b1;
    case (act)
      ACT_INSERT: begin
        if (shadow_count >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          // Equal keys stay in arrival order: land after every key <= the new one.
          pos = 0;
          while (pos < shadow_count && shadow_keys[pos] <= key) pos++;
          for (i = shadow_count; i > pos; i--) begin
            shadow_keys[i] = shadow_keys[i-1];
            shadow_payloads[i] = shadow_payloads[i-1];
          end
          shadow_keys[pos] = key;
          shadow_payloads[pos] = pay;
          shadow_count++;
        end
        r.entry_count = COUNT_W'(shadow_count);
        expected_words.push_back(r);
      end
      ACT_DELETE: begin
        kept = 0;
        for (i = 0; i < shadow_count; i++) begin
          if (shadow_keys[i] != key) begin
            shadow_keys[kept] = shadow_keys[i];
            shadow_payloads[kept] = shadow_payloads[i];
            kept++;
          end
        end
        r.removed = COUNT_W'(shadow_count - kept);
        shadow_count = kept;
        r.entry_count = COUNT_W'(shadow_count);
        expected_words.push_back(r);
      end
      ACT_READ: begin
        if (shadow_count == 0) begin
          r.status = STAT_EMPTY;
          expected_words.push_back(r);
        end else begin
          for (i = 0; i < shadow_count; i++) begin
            r.out_key = shadow_keys[i];
            r.out_payload = shadow_payloads[i];
            r.entry_count = COUNT_W'(shadow_count);
            r.last = (i == shadow_count - 1);
            expected_words.push_back(r);
          end
        end
      end
      default: begin
        // Unused action: nothing changes, one word with the current count.
        r.entry_count = COUNT_W'(shadow_count);
        expected_words.push_back(r);
      end
    endcase
  endtask

  task automatic queue_command(input action_t act, input logic signed [KEY_W-1:0] key,
                               input logic [PAYLOAD_W-1:0] pay);
    pending_commands.push_back('{act, key, pay});
  endtask

  // Stimulus: directed corner cases first, then random commands over a small key pool
  // so that duplicates, matching deletes and a full table come up often.
  initial begin
    int      n;
    int      roll;
    action_t act;
    logic signed [KEY_W-1:0] key;

    queue_command(ACT_READ,   32'sd0, 16'h0000);             // read out an empty table
    queue_command(ACT_DELETE, 32'sd7, 16'h0000);             // delete from an empty table
    queue_command(ACT_NONE,   32'sd0, 16'hFFFF);             // unused action code
    queue_command(ACT_INSERT, 32'sh7FFF_FFFF, 16'hFFFF);     // largest key
    queue_command(ACT_INSERT, 32'sh8000_0000, 16'h0000);     // smallest key
    queue_command(ACT_INSERT, 32'sd0, 16'h1234);
    queue_command(ACT_INSERT, 32'sd5, 16'h0001);             // equal keys keep arrival order
    queue_command(ACT_INSERT, 32'sd5, 16'h0002);
    queue_command(ACT_INSERT, 32'sd5, 16'h0003);
    queue_command(ACT_READ,   32'sd0, 16'h0000);
    queue_command(ACT_DELETE, 32'sd5, 16'h0000);             // removes all three at once
    queue_command(ACT_DELETE, 32'sd99, 16'h0000);            // no match
    for (n = 0; n < 13; n++)                                 // fill the table
      queue_command(ACT_INSERT, KEY_W'($urandom), 16'($urandom));
    queue_command(ACT_INSERT, 32'sd1, 16'hABCD);             // dropped: table full
    queue_command(ACT_READ,   32'sd0, 16'h0000);             // longest read-out
    queue_command(ACT_DELETE, 32'sh8000_0000, 16'h0000);

    for (n = 0; n < POOL_SIZE; n++) key_pool[n] = KEY_W'($urandom);
    key_pool[0] = 32'sh8000_0000;
    key_pool[1] = 32'sh7FFF_FFFF;
    key_pool[2] = -32'sd1;

    for (n = 0; n < RANDOM_WORDS; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 50)      act = ACT_INSERT;
      else if (roll < 72) act = ACT_DELETE;
      else if (roll < 95) act = ACT_READ;
      else                act = ACT_NONE;
      key = ($urandom_range(0, 3) == 0) ? KEY_W'($urandom)
                                         : key_pool[$urandom_range(0, POOL_SIZE - 1)];
      queue_command(act, key, 16'($urandom_range(0, 65535)));
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Wait for every command to go in, then for every predicted word to come out.
    while (pending_commands.size() > 0 || s_tvalid) @(posedge clk);
    while (expected_words.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_words.size() > 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Sender: hold a word until it is taken, then either idle a burst or offer the next one.
  always @(negedge clk) begin
    logic     next_valid;
    command_t item;
    if (!rst) begin
      next_valid = s_tvalid && !in_taken;
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_commands.size() > 0) begin
          if (pending_commands.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(0, 11);
          end else begin
            item = pending_commands.pop_front();
            s_tdata <= {item.pay, item.key};
            s_tuser <= item.act;
            next_valid = 1'b1;
          end
        end
      end
      s_tvalid <= next_valid;
    end
  end

  // Receiver: one long hold-off to back the block up, otherwise short random stalls.
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!long_hold_done && words_seen >= HOLD_AT) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (pending_commands.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 11);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Monitor: predict on every accepted command word, check every accepted result word.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    bit      busy;
    in_taken = 1'b0;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        in_taken = 1'b1;
        predict_results(action_t'(s_tuser), s_tdata[31:0], s_tdata[47:32]);
      end
      if (m_tvalid && m_tready) begin
        words_seen++;
        got.out_key     = m_tdata[31:0];
        got.out_payload = m_tdata[47:32];
        got.entry_count = m_tdata[52:48];
        got.removed     = m_tdata[57:53];
        got.status      = status_t'(m_tdata[59:58]);
        got.last        = m_tlast;
        if (expected_words.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected word: key %0d pay %h count %0d removed %0d status %0d last %0b",
                     got.out_key, got.out_payload, got.entry_count, got.removed, got.status,
                     got.last);
        end else begin
          want = expected_words.pop_front();
          if (got.out_key !== want.out_key || got.out_payload !== want.out_payload ||
              got.entry_count !== want.entry_count || got.removed !== want.removed ||
              got.status !== want.status || got.last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("mismatch word %0d expected: key %0d pay %h count %0d removed %0d status %0d last %0b",
                       words_seen, want.out_key, want.out_payload, want.entry_count,
                       want.removed, want.status, want.last);
              $display("mismatch word %0d actual:   key %0d pay %h count %0d removed %0d status %0d last %0b",
                       words_seen, got.out_key, got.out_payload, got.entry_count,
                       got.removed, got.status, got.last);
            end
          end
        end
      end
      // Watchdog: count cycles with work outstanding but no handshake on either side.
      busy = pending_commands.size() > 0 || s_tvalid || expected_words.size() > 0;
      if (busy && !(s_tvalid && s_tready) && !(m_tvalid && m_tready)) idle_cycles++;
      else idle_cycles = 0;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

endmodule

FILE: filelist.f
sv/skt_pkg.sv
sv/skt_cell.sv
sv/sorted_key_table.sv
verif/sorted_key_table_tb.sv
